// ===== sv/tspr_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-station pose package
// Shared constants: CORDIC arctangent table and the limit gain in Q30.
// ----------------------------------------------------------------------------
package tspr_pkg;

	localparam int TAB_LEN = 24;

	// Limit gain of the CORDIC iterations, scaled by 2^30.
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	// atan(2^-i) as 32-bit binary angles (2^32 is a full turn).
	localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

// ===== sv/tspr_rotate.sv =====
// ----------------------------------------------------------------------------
// Pipelined rotation CORDIC
// Turns (r, 0) by a binary angle; one register stage for gain and quadrant,
// then one stage per iteration.
// ----------------------------------------------------------------------------
module tspr_rotate #(
	parameter int W = 28,
	parameter int N = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] r,
	input  logic [31:0]         ang,
	output logic signed [W-1:0] xo,
	output logic signed [W-1:0] yo
);
	import tspr_pkg::*;

	logic signed [W-1:0] x_s [0:N];
	logic signed [W-1:0] y_s [0:N];
	logic signed [32:0]  z_s [0:N];

	logic signed [W+31:0] r_ext, g_ext, prod;
	logic signed [W-1:0]  x0;
	logic                 flip;
	logic [31:0]          a2;

	assign r_ext = {{32{r[W-1]}}, r};
	assign g_ext = (W+32)'(GAIN_Q30);
	assign prod  = r_ext * g_ext;
	assign x0    = prod[W+29:30];
	// Second and third quadrant angles are turned by half a turn first.
	assign flip  = ang[31] ^ ang[30];
	assign a2    = {ang[31] ^ flip, ang[30:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= flip ? -x0 : x0;
			y_s[0] <= '0;
			z_s[0] <= {a2[31], a2};
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({1'b0, ATAN_TAB[i]});
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({1'b0, ATAN_TAB[i]});
				end
			end
		end
	end

	assign xo = x_s[N];
	assign yo = y_s[N];

endmodule

// ===== sv/tspr_vector.sv =====
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// Drives a vector onto the x axis, giving its binary angle and scaled length.
// ----------------------------------------------------------------------------
module tspr_vector #(
	parameter int W = 32,
	parameter int N = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] xi,
	input  logic signed [W-1:0] yi,
	output logic [31:0]         ango,
	output logic signed [W-1:0] xo
);
	import tspr_pkg::*;

	logic signed [W-1:0] x_s [0:N];
	logic signed [W-1:0] y_s [0:N];
	logic [31:0]         z_s [0:N];

	// A vector in the left half plane is negated and starts at half a turn.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= xi[W-1] ? -xi : xi;
			y_s[0] <= xi[W-1] ? -yi : yi;
			z_s[0] <= xi[W-1] ? 32'h8000_0000 : 32'h0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end
			end
		end
	end

	assign ango = z_s[N];
	assign xo   = x_s[N];

endmodule

// ===== sv/two_station_pose_from_ranges.sv =====
// ----------------------------------------------------------------------------
// Two-station pose from ranges
// Polar pairs from two stations become target points; their midpoint and
// difference give the vessel position and heading.
// ----------------------------------------------------------------------------
//  channel  direction  word
//  s_*      in         left_pan, left_range, right_pan, right_range
//  m_*      out        pose_angle, pose_x, pose_y
//  cfg_*    in         station_baseline (always ready)
//
// The path runs through a rotation, a vectoring and a second rotation CORDIC
// pipeline, each CORDIC_STEPS+1 stages, plus combine, length and output
// stages. One word is taken per cycle while the output is not stalled. The
// whole pipeline holds when the output word is not taken, so nothing is lost
// or repeated. Reset clears the valid bits and loads the baseline of 1000 mm.
// ----------------------------------------------------------------------------
module two_station_pose_from_ranges #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // left_pan, left_range, right_pan, right_range
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // pose_angle, pose_x, pose_y, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import tspr_pkg::*;

	localparam int N  = CORDIC_STEPS;
	localparam int L  = 3 * N + 6;
	localparam int V4 = 2 * N + 3;

	logic          en;
	logic [L-1:0]  vld_q;
	logic [15:0]   baseline_q;

	assign en        = !vld_q[L-1] || m_tready;
	assign s_tready  = en;
	assign m_tvalid  = vld_q[L-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			baseline_q <= 16'd1000;
		end else begin
			if (en) vld_q <= {vld_q[L-2:0], s_tvalid};
			if (cfg_valid) baseline_q <= cfg_data;
		end
	end

	// Stage 1: both stations' polar pairs to Cartesian.
	logic signed [27:0] cl, sl, cr, sr;

	tspr_rotate #(.W(28), .N(N)) u_rot_l (
		.clk(clk), .en(en),
		.r({4'b0, s_tdata[31:16], 8'b0}), .ang({s_tdata[15:0], 16'b0}),
		.xo(cl), .yo(sl)
	);

	tspr_rotate #(.W(28), .N(N)) u_rot_r (
		.clk(clk), .en(en),
		.r({4'b0, s_tdata[63:48], 8'b0}), .ang({s_tdata[47:32], 16'b0}),
		.xo(cr), .yo(sr)
	);

	// Stage 2: target points, midpoint and difference.
	logic signed [27:0] half, lx, rx, dx, dy;
	logic signed [28:0] sum_x, sum_y;
	logic signed [31:0] mx_s2, my_s2, dx_s2, dy_s2;
	logic               coin_s2;

	assign half  = {5'b0, baseline_q, 7'b0};
	assign lx    = sl - half;
	assign rx    = sr + half;
	assign sum_x = {lx[27], lx} + {rx[27], rx};
	assign sum_y = {cl[27], cl} + {cr[27], cr};
	assign dx    = lx - rx;
	assign dy    = cl - cr;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2   <= 32'($signed(sum_x[28:1]));
			my_s2   <= 32'($signed(sum_y[28:1]));
			dx_s2   <= 32'(dx);
			dy_s2   <= 32'(dy);
			coin_s2 <= (dx == 0) && (dy == 0);
		end
	end

	// Stage 3: rotation from the difference, length from the midpoint.
	logic [31:0]        rot_v;
	logic signed [31:0] mlen_v;
	logic               coin_d [0:N];

	tspr_vector #(.W(32), .N(N)) u_vec_d (
		.clk(clk), .en(en), .xi(dx_s2), .yi(dy_s2), .ango(rot_v), .xo()
	);

	tspr_vector #(.W(32), .N(N)) u_vec_m (
		.clk(clk), .en(en), .xi(mx_s2), .yi(my_s2), .ango(), .xo(mlen_v)
	);

	always_ff @(posedge clk) begin
		if (en) coin_d[0] <= coin_s2;
	end
	for (genvar k = 0; k < N; k++) begin : g_coin
		always_ff @(posedge clk) begin
			if (en) coin_d[k+1] <= coin_d[k];
		end
	end

	// Stage 4: length scaling by the gain.
	logic signed [63:0] len_prod;
	logic signed [29:0] len_s4;
	logic [31:0]        rot_s4;

	assign len_prod = 64'(mlen_v) * 64'(GAIN_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			len_s4 <= len_prod[59:30];
			rot_s4 <= coin_d[N] ? 32'h0 : rot_v;
		end
	end

	// Stage 5: position from rotation and length; heading travels alongside.
	logic signed [29:0] px, py;
	logic [31:0]        rot_rnd;
	logic [15:0]        ang_d [0:N];

	tspr_rotate #(.W(30), .N(N)) u_rot_p (
		.clk(clk), .en(en), .r(len_s4), .ang(rot_s4), .xo(px), .yo(py)
	);

	assign rot_rnd = rot_s4 + 32'h0000_8000;

	always_ff @(posedge clk) begin
		if (en) ang_d[0] <= -rot_rnd[31:16];
	end
	for (genvar k = 0; k < N; k++) begin : g_ang
		always_ff @(posedge clk) begin
			if (en) ang_d[k+1] <= ang_d[k];
		end
	end

	// Stage 6: rounding to millimetres and saturation.
	logic signed [29:0] px_r, py_r;
	logic signed [21:0] px_m, py_m;
	logic [18:0]        px_sat, py_sat;
	logic [55:0]        out_s6;

	assign px_r = px + 30'sd128;
	assign py_r = py + 30'sd128;
	assign px_m = px_r[29:8];
	assign py_m = py_r[29:8];

	always_comb begin
		if (px_m > 22'sd262143)       px_sat = 19'h3FFFF;
		else if (px_m < -22'sd262144) px_sat = 19'h40000;
		else                          px_sat = px_m[18:0];
		if (py_m > 22'sd262143)       py_sat = 19'h3FFFF;
		else if (py_m < -22'sd262144) py_sat = 19'h40000;
		else                          py_sat = py_m[18:0];
	end

	always_ff @(posedge clk) begin
		if (en) out_s6 <= {2'b0, py_sat, px_sat, ang_d[N]};
	end

	assign m_tdata = out_s6;

	// A taken word always enters the valid chain.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted word did not enter the pipeline");

	// While the output stalls, no word may move or vanish.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(vld_q))
		else $error("valid chain moved during a stall");

	// The midpoint length is never negative.
	a_len_positive: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[V4] |-> !len_s4[29])
		else $error("negative midpoint length");

endmodule
